@@ rtl/qpgs_pkg.sv @@
// ----------------------------------------------------------------------------
// qpgs_pkg
// Shared types, register indexes and constants of the quad panner with
// smoothed gains.
// ----------------------------------------------------------------------------
`default_nettype none

package qpgs_pkg;

  // Default widths of the data path.
  localparam int SAMPLE_BITS_DEF    = 24;
  localparam int GAIN_FRAC_BITS_DEF = 23;
  localparam int COEF_BITS_DEF      = 16;

  // Register indexes on the configuration port.
  localparam logic [1:0] CFG_IDX_LEFT_RIGHT = 2'd0;
  localparam logic [1:0] CFG_IDX_FRONT_REAR = 2'd1;
  localparam logic [1:0] CFG_IDX_COEF       = 2'd2;

  // Reset value of the smoothing pole before it is cut to the coefficient width.
  localparam logic [31:0] COEF_RESET = 32'd65279;

  // Remaining percentage (0..100) and the product of two of them (0..10000).
  localparam int PCT_BITS  = 7;
  localparam int PROD_BITS = 14;
  localparam logic [PCT_BITS-1:0] PCT_FULL = 7'd100;

  // Division of the percentage product by 10000 by way of a reciprocal.
  localparam int              RECIP_SHIFT = 14;
  localparam logic [PROD_BITS-1:0] PCT_DIV = 14'd10000;

  // Cycles the gain pipeline needs to settle after a register write.
  localparam int          SETTLE_BITS = 3;
  localparam logic [SETTLE_BITS-1:0] SETTLE_CYCLES = 3'd5;

  // Control of one lane for the current cycle.
  typedef struct packed {
    logic load;   // a frame transfer is taken in this cycle
    logic clear;  // the smoother state is set back to zero
  } lane_ctrl_t;

  // Saturate a raw pan byte to the range -100..+100.
  function automatic logic signed [7:0] sat_pan(input logic [7:0] raw);
    logic signed [7:0] v;
    v = signed'(raw);
    if (v > 8'sd100) begin
      return 8'sd100;
    end else if (v < -8'sd100) begin
      return -8'sd100;
    end
    return v;
  endfunction

endpackage

`default_nettype wire

@@ rtl/quad_panner_gain_smoother.sv @@
// ----------------------------------------------------------------------------
// quad_panner_gain_smoother
// Four-channel panner: each channel of a frame is scaled by its own gain,
// smoothed by a one-pole filter, with the targets set by two pan registers.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake            Payload
//  in       sink       in_valid/in_ready    four samples, SAMPLE_BITS each
//  out      source     out_valid/out_ready  four scaled samples
//  cfg      sink       cfg_we               cfg_index, cfg_wdata
//
//  One frame transfer per cycle is sustained; a frame is registered in the
//  lanes and then in the output register. The limit is the smoother loop:
//  each lane updates its gain state once per frame.
//  After reset and after every register write the gain pipeline
//  recomputes the targets; in_ready is low until it has settled.
//  Reset (rst_n, synchronous) clears pans, valids and smoothers, presets coef_r.
//  A stall on out_ready holds the whole frame path; nothing is dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module quad_panner_gain_smoother #(
  parameter int SAMPLE_BITS    = qpgs_pkg::SAMPLE_BITS_DEF,
  parameter int GAIN_FRAC_BITS = qpgs_pkg::GAIN_FRAC_BITS_DEF,
  parameter int COEF_BITS      = qpgs_pkg::COEF_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // Configuration write port.
  input  wire logic                   cfg_we,
  input  wire logic [1:0]             cfg_index,
  input  wire logic [COEF_BITS-1:0]   cfg_wdata,
  // Frame input.
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [SAMPLE_BITS-1:0] in_front_left_in,
  input  wire logic [SAMPLE_BITS-1:0] in_front_right_in,
  input  wire logic [SAMPLE_BITS-1:0] in_rear_left_in,
  input  wire logic [SAMPLE_BITS-1:0] in_rear_right_in,
  // Frame output.
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [SAMPLE_BITS-1:0]      out_front_left_out,
  output logic [SAMPLE_BITS-1:0]      out_front_right_out,
  output logic [SAMPLE_BITS-1:0]      out_rear_left_out,
  output logic [SAMPLE_BITS-1:0]      out_rear_right_out
);
  import qpgs_pkg::*;

  localparam int NLANES = 4;
  localparam int GW     = GAIN_FRAC_BITS + 1;
  localparam int GAW    = GAIN_FRAC_BITS + COEF_BITS + 2;
  localparam logic [COEF_BITS-1:0] COEF_RST = COEF_RESET[COEF_BITS-1:0];
  localparam logic [GW-1:0]        UNITY    = GW'(1) << GAIN_FRAC_BITS;

  // --------------------------------------------------------------------------
  // Configuration registers. Pan values are saturated as they are written.
  // --------------------------------------------------------------------------
  logic signed [7:0]      lr_r, fr_r;
  logic [COEF_BITS-1:0]   coef_r;
  logic [SETTLE_BITS-1:0] settle_r;
  logic                   coef_wr;

  assign coef_wr = cfg_we && (cfg_index == CFG_IDX_COEF);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lr_r     <= '0;
      fr_r     <= '0;
      coef_r   <= COEF_RST;
      settle_r <= SETTLE_CYCLES;
    end else begin
      if (cfg_we) begin
        settle_r <= SETTLE_CYCLES;
      end else if (settle_r != '0) begin
        settle_r <= settle_r - SETTLE_BITS'(1);
      end
      if (cfg_we && (cfg_index == CFG_IDX_LEFT_RIGHT)) begin
        lr_r <= sat_pan(cfg_wdata[7:0]);
      end
      if (cfg_we && (cfg_index == CFG_IDX_FRONT_REAR)) begin
        fr_r <= sat_pan(cfg_wdata[7:0]);
      end
      if (coef_wr) begin
        coef_r <= cfg_wdata;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Remaining percentage of each side. A negative left/right value takes
  // from the right pair, a positive one from the left pair; front/rear alike.
  // --------------------------------------------------------------------------
  logic [PCT_BITS-1:0] left_pct_r, right_pct_r, front_pct_r, rear_pct_r;
  logic signed [7:0]   lr_rem, fr_rem;

  assign lr_rem = (lr_r < 0) ? (8'sd100 + lr_r) : (8'sd100 - lr_r);
  assign fr_rem = (fr_r < 0) ? (8'sd100 + fr_r) : (8'sd100 - fr_r);

  always_ff @(posedge clk) begin
    left_pct_r  <= (lr_r < 0) ? PCT_FULL : lr_rem[PCT_BITS-1:0];
    right_pct_r <= (lr_r < 0) ? lr_rem[PCT_BITS-1:0] : PCT_FULL;
    front_pct_r <= (fr_r < 0) ? PCT_FULL : fr_rem[PCT_BITS-1:0];
    rear_pct_r  <= (fr_r < 0) ? fr_rem[PCT_BITS-1:0] : PCT_FULL;
  end

  // --------------------------------------------------------------------------
  // Frame flow: one stage holds the frame whose gains were just updated,
  // then the merge stage collects the four lane results in the output
  // register. Everything advances when the output register is free.
  // --------------------------------------------------------------------------
  logic       adv, in_xfer;
  logic       s1_valid_r, out_valid_r;
  lane_ctrl_t lane_ctrl;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv && (settle_r == '0);
  assign in_xfer  = in_valid && in_ready;

  assign lane_ctrl.load  = in_xfer;
  assign lane_ctrl.clear = coef_wr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r  <= in_xfer;
      out_valid_r <= s1_valid_r;
    end
  end

  // --------------------------------------------------------------------------
  // Lanes: front left, front right, rear left, rear right.
  // --------------------------------------------------------------------------
  logic [COEF_BITS:0]      coef_a;
  logic [PCT_BITS-1:0]     pct_h  [NLANES];
  logic [PCT_BITS-1:0]     pct_v  [NLANES];
  logic [SAMPLE_BITS-1:0]  lane_in[NLANES];
  logic [SAMPLE_BITS-1:0]  scaled [NLANES];
  logic [GW-1:0]           gain   [NLANES];
  logic [GAW-1:0]          ga     [NLANES];
  logic [SAMPLE_BITS-1:0]  out_r  [NLANES];

  assign coef_a = ((COEF_BITS+1)'(1) << COEF_BITS) - (COEF_BITS+1)'(coef_r);

  assign pct_h[0] = left_pct_r;   assign pct_v[0] = front_pct_r;
  assign pct_h[1] = right_pct_r;  assign pct_v[1] = front_pct_r;
  assign pct_h[2] = left_pct_r;   assign pct_v[2] = rear_pct_r;
  assign pct_h[3] = right_pct_r;  assign pct_v[3] = rear_pct_r;

  assign lane_in[0] = in_front_left_in;
  assign lane_in[1] = in_front_right_in;
  assign lane_in[2] = in_rear_left_in;
  assign lane_in[3] = in_rear_right_in;

  for (genvar i = 0; i < NLANES; i++) begin : g_lane
    qpgs_target #(
      .GAIN_FRAC_BITS(GAIN_FRAC_BITS),
      .COEF_BITS     (COEF_BITS)
    ) u_target (
      .clk   (clk),
      .pct_h (pct_h[i]),
      .pct_v (pct_v[i]),
      .coef_a(coef_a),
      .ga    (ga[i])
    );

    qpgs_lane #(
      .SAMPLE_BITS   (SAMPLE_BITS),
      .GAIN_FRAC_BITS(GAIN_FRAC_BITS),
      .COEF_BITS     (COEF_BITS)
    ) u_lane (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (lane_ctrl),
      .sample_in(lane_in[i]),
      .ga       (ga[i]),
      .coef_b   (coef_r),
      .scaled   (scaled[i]),
      .gain     (gain[i])
    );

    // Merge stage: the output register of this channel.
    always_ff @(posedge clk) begin
      if (adv && s1_valid_r) begin
        out_r[i] <= scaled[i];
      end
    end
  end

  assign out_valid           = out_valid_r;
  assign out_front_left_out  = out_r[0];
  assign out_front_right_out = out_r[1];
  assign out_rear_left_out   = out_r[2];
  assign out_rear_right_out  = out_r[3];

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // A register write keeps frames out until the gain pipeline has settled.
  a_settle_after_cfg: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> !in_ready)
    else $error("frame taken while gains were being recomputed");

  // A coefficient write leaves all four smoothers at zero.
  a_clear_on_coef: assert property (@(posedge clk) disable iff (!rst_n)
    coef_wr |=> (gain[0] == '0) && (gain[1] == '0) && (gain[2] == '0) &&
                (gain[3] == '0))
    else $error("smoother not cleared by coefficient write");

  // The smoothed gains never exceed unity.
  a_gain_unity: assert property (@(posedge clk) disable iff (!rst_n)
    (gain[0] <= UNITY) && (gain[1] <= UNITY) && (gain[2] <= UNITY) &&
    (gain[3] <= UNITY))
    else $error("smoothed gain above unity");

  // A result leaves the output register only after a frame passed the lanes.
  a_out_from_s1: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_valid_r))
    else $error("output valid without a frame in the lanes");

endmodule

`default_nettype wire

@@ rtl/qpgs_target.sv @@
// ----------------------------------------------------------------------------
// qpgs_target
// Target gain of one lane and its share g*(1-b) of the smoother update.
// ----------------------------------------------------------------------------
`default_nettype none

module qpgs_target #(
  parameter int GAIN_FRAC_BITS = qpgs_pkg::GAIN_FRAC_BITS_DEF,
  parameter int COEF_BITS      = qpgs_pkg::COEF_BITS_DEF
) (
  input  wire logic                                  clk,
  input  wire logic [qpgs_pkg::PCT_BITS-1:0]         pct_h,
  input  wire logic [qpgs_pkg::PCT_BITS-1:0]         pct_v,
  input  wire logic [COEF_BITS:0]                    coef_a,
  output logic      [GAIN_FRAC_BITS+COEF_BITS+1:0]   ga
);
  import qpgs_pkg::*;

  localparam int GW = GAIN_FRAC_BITS + 1;
  localparam int XW = GAIN_FRAC_BITS + PROD_BITS + 1;
  localparam logic [63:0] RECIP_FULL =
    (64'd1 << (GAIN_FRAC_BITS + RECIP_SHIFT)) / 64'd10000;
  localparam logic [GW-1:0] RECIP = RECIP_FULL[GW-1:0];

  logic [PROD_BITS-1:0] prod_r, prod_d_r;
  logic [GW-1:0]        qe_r, tgt_r;
  logic [GAIN_FRAC_BITS+COEF_BITS+1:0] ga_r;

  logic [PROD_BITS+GW-1:0] qe_full;
  logic [XW-1:0]           x_val, q_mul, rem;
  logic [GW-1:0]           tgt_nxt;

  // Estimate is at most one below the true quotient; one correction step.
  assign qe_full = PROD_BITS'(prod_r) * RECIP;
  assign x_val   = {1'b0, prod_d_r, {GAIN_FRAC_BITS{1'b0}}};
  assign q_mul   = XW'(qe_r) * XW'(PCT_DIV);
  assign rem     = x_val - q_mul;
  assign tgt_nxt = (rem >= XW'(PCT_DIV)) ? qe_r + GW'(1) : qe_r;

  always_ff @(posedge clk) begin
    prod_r   <= PROD_BITS'(pct_h) * PROD_BITS'(pct_v);
    prod_d_r <= prod_r;
    qe_r     <= qe_full[RECIP_SHIFT +: GW];
    tgt_r    <= tgt_nxt;
    ga_r     <= (GAIN_FRAC_BITS+COEF_BITS+2)'(tgt_r) *
                (GAIN_FRAC_BITS+COEF_BITS+2)'(coef_a);
  end

  assign ga = ga_r;

endmodule

`default_nettype wire

@@ rtl/qpgs_lane.sv @@
// ----------------------------------------------------------------------------
// qpgs_lane
// One channel: one-pole gain smoother and the scaling multiply.
// ----------------------------------------------------------------------------
`default_nettype none

module qpgs_lane #(
  parameter int SAMPLE_BITS    = qpgs_pkg::SAMPLE_BITS_DEF,
  parameter int GAIN_FRAC_BITS = qpgs_pkg::GAIN_FRAC_BITS_DEF,
  parameter int COEF_BITS      = qpgs_pkg::COEF_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire qpgs_pkg::lane_ctrl_t                ctrl,
  input  wire logic [SAMPLE_BITS-1:0]              sample_in,
  input  wire logic [GAIN_FRAC_BITS+COEF_BITS+1:0] ga,
  input  wire logic [COEF_BITS-1:0]                coef_b,
  output logic      [SAMPLE_BITS-1:0]              scaled,
  output logic      [GAIN_FRAC_BITS:0]             gain
);
  import qpgs_pkg::*;

  localparam int GW = GAIN_FRAC_BITS + 1;
  localparam int SW = GAIN_FRAC_BITS + COEF_BITS + 2;
  localparam int PW = SAMPLE_BITS + GAIN_FRAC_BITS + 2;

  logic [GW-1:0]          z_r, z_nxt;
  logic [SAMPLE_BITS-1:0] sample_r;
  logic [SW-1:0]          zb, zsum;
  logic signed [PW-1:0]   prod;

  assign zb    = SW'(z_r) * SW'(coef_b);
  assign zsum  = ga + zb;
  assign z_nxt = zsum[COEF_BITS +: GW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      z_r <= '0;
    end else if (ctrl.clear) begin
      z_r <= '0;
    end else if (ctrl.load) begin
      z_r <= z_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      sample_r <= sample_in;
    end
  end

  // Arithmetic shift of the product rounds toward minus infinity.
  assign prod   = PW'(signed'(sample_r)) * signed'({1'b0, z_r});
  assign scaled = prod[GAIN_FRAC_BITS +: SAMPLE_BITS];
  assign gain   = z_r;

endmodule

`default_nettype wire
